// File: rtl/dsas_pkg.sv
// ----------------------------------------------------------------------------
// Deadline-sorted alarm scheduler package
// Shared event codes, controller states and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package dsas_pkg;

	// Event codes carried by the mode field.
	typedef enum logic [1:0] {
		MODE_SET      = 2'd0,
		MODE_CANCEL   = 2'd1,
		MODE_DISPATCH = 2'd2,
		MODE_QUERY    = 2'd3
	} mode_t;

	// Address source for the deadline memory read port.
	typedef enum logic [1:0] {
		RD_FRONT = 2'd0,
		RD_TGT   = 2'd1,
		RD_POS   = 2'd2
	} rd_sel_t;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SET,
		ST_CANCEL,
		ST_DRD,
		ST_DCMP,
		ST_FIRE,
		ST_PRD,
		ST_DIV,
		ST_DLC,
		ST_INS_RD,
		ST_INS_CMP,
		ST_INS_PUT,
		ST_QRD,
		ST_QCMP,
		ST_FRD,
		ST_FIN
	} state_t;

	// Configuration register file.
	localparam int unsigned APB_AW   = 3;
	localparam int unsigned THRESH_W = 20;
	localparam logic [THRESH_W-1:0] THRESH_RESET = 20'd3000;
	localparam logic [APB_AW-3:0]   REG_THRESH   = 1'b0;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    capture;
		logic    set_load;
		logic    cancel_op;
		logic    unlink;
		logic    fire_check;
		logic    fire_step;
		logic    per_load;
		logic    dl_calc;
		logic    ins_step;
		logic    ins_put;
		logic    q_calc;
		logic    finish;
		rd_sel_t rd_sel;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		mode_t in_mode;
		logic  in_id_ok;
		logic  pos_lt_cnt;
		logic  ins_adv;
		logic  fire_ok;
		logic  rep_tgt;
		logic  per_zero;
		logic  div_busy;
		logic  out_free;
	} stat_t;

endpackage

// File: rtl/dsas_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dsas_ram #(
	parameter int unsigned WIDTH = 48,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/dsas_mod.sv
// ----------------------------------------------------------------------------
// Iterative modulo unit
// Restoring division, one quotient bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module dsas_mod #(
	parameter int unsigned TW = 48
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [TW-1:0] dvd,
	input  logic [TW-1:0] dvs,
	output logic          busy,
	output logic [TW-1:0] rem
);

	localparam int unsigned CTW = $clog2(TW + 1);

	logic          busy_q;
	logic [CTW-1:0] cnt_q;
	logic [TW-1:0] dvd_q;
	logic [TW-1:0] dvs_q;
	logic [TW-1:0] rem_q;
	logic [TW:0]   trial;
	logic [TW:0]   diff;

	// One shift-and-subtract step.
	always_comb begin
		trial = {rem_q, dvd_q[TW-1]};
		diff  = trial - {1'b0, dvs_q};
		if (trial < {1'b0, dvs_q}) begin
			diff = trial;
		end
	end

	// Control of the step count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CTW'(TW);
		end else if (busy_q) begin
			busy_q <= (cnt_q != CTW'(1));
			cnt_q  <= cnt_q - CTW'(1);
		end
	end

	// Operand and remainder registers.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dvd;
			dvs_q <= dvs;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[TW-2:0], 1'b0};
			rem_q <= diff[TW-1:0];
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule

// File: rtl/dsas_datapath.sv
// ----------------------------------------------------------------------------
// Alarm scheduler datapath
// Slot memories, the deadline-ordered slot list, deadline arithmetic and
// the result register.
// ----------------------------------------------------------------------------
module dsas_datapath #(
	parameter int unsigned ALARM_SLOTS = 16,
	parameter int unsigned TIME_WIDTH  = 48
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dsas_pkg::cmd_t                cmd,
	output dsas_pkg::stat_t               stat,
	input  logic [dsas_pkg::THRESH_W-1:0] thresh,
	input  logic [1:0]                    mode,
	input  logic [3:0]                    alarm_id,
	input  logic [47:0]                   alarm_interval,
	input  logic                          periodic,
	input  logic [47:0]                   now_ms,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          fired,
	output logic [3:0]                    fired_id,
	output logic [47:0]                   time_left,
	output logic                          is_pending,
	output logic                          has_front,
	output logic [47:0]                   front_deadline_ms,
	output logic                          short_wait
);

	localparam int unsigned N  = ALARM_SLOTS;
	localparam int unsigned TW = TIME_WIDTH;
	localparam int unsigned AW = $clog2(N);
	localparam int unsigned CW = $clog2(N + 1);

	// Item registers.
	logic [TW-1:0] now_q;
	logic [TW-1:0] intv_q;
	logic          per_in_q;
	logic          id_ok_q;
	logic [AW-1:0] qid_q;
	logic [AW-1:0] tgt_q;
	logic          upd_q;
	logic          fired_q;
	logic [AW-1:0] fid_q;
	logic [TW-1:0] rem_q;
	logic [TW-1:0] per_q;
	logic          use_div_q;
	logic [TW-1:0] dl_q;
	logic [CW-1:0] pos_q;

	// Scheduler state.
	logic [AW-1:0] ord_q [N];
	logic [CW-1:0] cnt_q;
	logic [N-1:0]  pend_q;
	logic [N-1:0]  rep_q;
	logic [N-1:0]  dlwr_q;
	logic          sw_q;
	logic [AW-1:0] rda_q;

	// Result register.
	logic          ov_q;
	logic          o_fired_q;
	logic [3:0]    o_fid_q;
	logic [47:0]   o_rem_q;
	logic          o_pend_q;
	logic          o_front_q;
	logic [47:0]   o_fdl_q;
	logic          o_sw_q;

	// Memory ports.
	logic          dl_we;
	logic [TW-1:0] dl_wdata;
	logic [AW-1:0] dl_raddr;
	logic [TW-1:0] dl_rdata;
	logic [TW-1:0] rd_dl;
	logic [TW-1:0] st_rdata;
	logic [TW-1:0] per_rdata;

	// Arithmetic and list helpers.
	logic [TW-1:0] div_rem;
	logic          div_busy;
	logic [TW-1:0] phase;
	logic [TW:0]   dl_sum;
	logic [TW-1:0] dl_new;
	logic [N-1:0]  hit;
	logic [N-1:0]  shf;
	logic          seen;
	logic [AW-1:0] ord_unl [N];
	logic [AW-1:0] ord_ins [N];
	logic          id_ok_in;
	logic [AW-1:0] id_in;
	logic [TW-1:0] now_in;
	logic          front_near;
	logic          sw_new;
	logic          has_any;

	assign id_ok_in = (32'(alarm_id) < N);
	assign id_in    = AW'(alarm_id);
	assign now_in   = TW'(now_ms);
	assign has_any  = (cnt_q != '0);

	// Deadline memory read address and the zero-until-written mask.
	always_comb begin
		unique case (cmd.rd_sel)
			dsas_pkg::RD_FRONT: dl_raddr = ord_q[0];
			dsas_pkg::RD_TGT:   dl_raddr = tgt_q;
			dsas_pkg::RD_POS:   dl_raddr = ord_q[pos_q[AW-1:0]];
			default:            dl_raddr = ord_q[0];
		endcase
	end

	assign rd_dl = dlwr_q[rda_q] ? dl_rdata : '0;

	// Next deadline: now plus period minus phase, saturating.
	assign phase  = use_div_q ? div_rem : '0;
	assign dl_sum = {1'b0, now_q} + {1'b0, per_q - phase};
	assign dl_new = dl_sum[TW] ? '1 : dl_sum[TW-1:0];

	assign dl_we    = cmd.dl_calc | cmd.cancel_op | (cmd.fire_step & ~rep_q[tgt_q]);
	assign dl_wdata = cmd.dl_calc ? dl_new : '0;

	dsas_ram #(.WIDTH(TW), .DEPTH(N)) u_dl_ram (
		.clk   (clk),
		.we    (dl_we),
		.waddr (tgt_q),
		.wdata (dl_wdata),
		.raddr (dl_raddr),
		.rdata (dl_rdata)
	);

	dsas_ram #(.WIDTH(TW), .DEPTH(N)) u_start_ram (
		.clk   (clk),
		.we    (cmd.set_load),
		.waddr (tgt_q),
		.wdata (now_q),
		.raddr (tgt_q),
		.rdata (st_rdata)
	);

	dsas_ram #(.WIDTH(TW), .DEPTH(N)) u_period_ram (
		.clk   (clk),
		.we    (cmd.set_load),
		.waddr (tgt_q),
		.wdata (intv_q),
		.raddr (tgt_q),
		.rdata (per_rdata)
	);

	dsas_mod #(.TW(TW)) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.per_load & (per_rdata != '0)),
		.dvd    (now_q - st_rdata),
		.dvs    (per_rdata),
		.busy   (div_busy),
		.rem    (div_rem)
	);

	// Removal of the target slot: every entry at or after it moves up one.
	always_comb begin
		seen = 1'b0;
		for (int j = 0; j < N; j++) begin
			hit[j] = (CW'(j) < cnt_q) && (ord_q[j] == tgt_q);
			seen   = seen | hit[j];
			shf[j] = seen;
		end
		for (int j = 0; j < N - 1; j++) begin
			ord_unl[j] = shf[j] ? ord_q[j+1] : ord_q[j];
		end
		ord_unl[N-1] = ord_q[N-1];
	end

	// Insertion of the target slot at the walk position.
	always_comb begin
		ord_ins[0] = (pos_q == '0) ? tgt_q : ord_q[0];
		for (int j = 1; j < N; j++) begin
			if (CW'(j) > pos_q) begin
				ord_ins[j] = ord_q[j-1];
			end else if (CW'(j) == pos_q) begin
				ord_ins[j] = tgt_q;
			end else begin
				ord_ins[j] = ord_q[j];
			end
		end
	end

	// Short-wait flag from the front deadline.
	assign front_near = (rd_dl < now_q) || ((rd_dl - now_q) < TW'(thresh));
	assign sw_new     = upd_q ? (has_any && front_near) : sw_q;

	// Control state of the scheduler.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			pend_q <= '0;
			rep_q  <= '0;
			dlwr_q <= '0;
			sw_q   <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			if (cmd.unlink) begin
				if (|hit) begin
					cnt_q <= cnt_q - CW'(1);
				end
				pend_q[tgt_q] <= 1'b0;
			end
			if (cmd.ins_put) begin
				cnt_q         <= cnt_q + CW'(1);
				pend_q[tgt_q] <= 1'b1;
			end
			if (cmd.set_load) begin
				rep_q[tgt_q] <= per_in_q;
			end
			if (dl_we) begin
				dlwr_q[tgt_q] <= 1'b1;
			end
			if (cmd.finish) begin
				sw_q <= sw_new;
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Slot order list.
	always_ff @(posedge clk) begin
		if (cmd.unlink) begin
			ord_q <= ord_unl;
		end else if (cmd.ins_put) begin
			ord_q <= ord_ins;
		end
	end

	// Item registers, updated under command.
	always_ff @(posedge clk) begin
		rda_q <= dl_raddr;
		if (cmd.capture) begin
			now_q    <= now_in;
			intv_q   <= TW'(alarm_interval);
			per_in_q <= periodic;
			id_ok_q  <= id_ok_in;
			qid_q    <= id_in;
			tgt_q    <= id_in;
			fired_q  <= 1'b0;
			fid_q    <= '0;
			rem_q    <= '0;
			upd_q    <= (mode == dsas_pkg::MODE_DISPATCH) ||
			            (((mode == dsas_pkg::MODE_SET) || (mode == dsas_pkg::MODE_CANCEL)) &&
			             id_ok_in && has_any && (ord_q[0] == id_in));
		end
		if (cmd.set_load) begin
			per_q     <= intv_q;
			use_div_q <= 1'b0;
		end
		if (cmd.fire_check && stat.fire_ok) begin
			fired_q <= 1'b1;
			fid_q   <= ord_q[0];
			tgt_q   <= ord_q[0];
		end
		if (cmd.per_load) begin
			per_q     <= per_rdata;
			use_div_q <= (per_rdata != '0);
		end
		if (cmd.dl_calc) begin
			dl_q  <= dl_new;
			pos_q <= '0;
		end
		if (cmd.ins_step && stat.ins_adv) begin
			pos_q <= pos_q + CW'(1);
		end
		if (cmd.ins_put && (pos_q == '0)) begin
			upd_q <= 1'b1;
		end
		if (cmd.q_calc && (rd_dl > now_q)) begin
			rem_q <= rd_dl - now_q;
		end
	end

	// Result register load; the pending bit is reported for the addressed slot.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			o_fired_q <= fired_q;
			o_fid_q   <= 4'(fid_q);
			o_rem_q   <= 48'(rem_q);
			o_pend_q  <= id_ok_q && pend_q[qid_q];
			o_front_q <= has_any;
			o_fdl_q   <= has_any ? 48'(rd_dl) : '0;
			o_sw_q    <= sw_new;
		end
	end

	// Status toward the controller.
	always_comb begin
		stat.in_mode    = dsas_pkg::mode_t'(mode);
		stat.in_id_ok   = id_ok_in;
		stat.pos_lt_cnt = (pos_q < cnt_q);
		stat.ins_adv    = (rd_dl <= dl_q);
		stat.fire_ok    = has_any && (rd_dl <= now_q);
		stat.rep_tgt    = rep_q[tgt_q];
		stat.per_zero   = (per_rdata == '0);
		stat.div_busy   = div_busy;
		stat.out_free   = !ov_q || out_ready;
	end

	assign out_valid         = ov_q;
	assign fired             = o_fired_q;
	assign fired_id          = o_fid_q;
	assign time_left         = o_rem_q;
	assign is_pending        = o_pend_q;
	assign has_front         = o_front_q;
	assign front_deadline_ms = o_fdl_q;
	assign short_wait        = o_sw_q;

endmodule

// File: rtl/dsas_ctrl.sv
// ----------------------------------------------------------------------------
// Alarm scheduler controller
// Sequences each event through the steps its mode needs: removal, deadline computation,
// the ordered insertion walk, the query read and the result transfer.
// ----------------------------------------------------------------------------
module dsas_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  dsas_pkg::stat_t stat,
	output dsas_pkg::cmd_t  cmd
);

	dsas_pkg::state_t state_q;
	dsas_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsas_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.rd_sel = dsas_pkg::RD_FRONT;
		in_ready   = 1'b0;
		unique case (state_q)
			dsas_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					unique case (stat.in_mode)
						dsas_pkg::MODE_SET:
							state_d = stat.in_id_ok ? dsas_pkg::ST_SET : dsas_pkg::ST_FRD;
						dsas_pkg::MODE_CANCEL:
							state_d = stat.in_id_ok ? dsas_pkg::ST_CANCEL : dsas_pkg::ST_FRD;
						dsas_pkg::MODE_DISPATCH:
							state_d = dsas_pkg::ST_DRD;
						dsas_pkg::MODE_QUERY:
							state_d = stat.in_id_ok ? dsas_pkg::ST_QRD : dsas_pkg::ST_FRD;
						default:
							state_d = dsas_pkg::ST_FRD;
					endcase
				end
			end
			dsas_pkg::ST_SET: begin
				cmd.set_load = 1'b1;
				cmd.unlink   = 1'b1;
				state_d      = dsas_pkg::ST_DLC;
			end
			dsas_pkg::ST_CANCEL: begin
				cmd.cancel_op = 1'b1;
				cmd.unlink    = 1'b1;
				state_d       = dsas_pkg::ST_FRD;
			end
			dsas_pkg::ST_DRD: begin
				state_d = dsas_pkg::ST_DCMP;
			end
			dsas_pkg::ST_DCMP: begin
				cmd.fire_check = 1'b1;
				state_d        = stat.fire_ok ? dsas_pkg::ST_FIRE : dsas_pkg::ST_FRD;
			end
			dsas_pkg::ST_FIRE: begin
				cmd.fire_step = 1'b1;
				cmd.unlink    = 1'b1;
				state_d       = stat.rep_tgt ? dsas_pkg::ST_PRD : dsas_pkg::ST_FRD;
			end
			dsas_pkg::ST_PRD: begin
				cmd.per_load = 1'b1;
				state_d      = stat.per_zero ? dsas_pkg::ST_DLC : dsas_pkg::ST_DIV;
			end
			dsas_pkg::ST_DIV: begin
				if (!stat.div_busy) begin
					state_d = dsas_pkg::ST_DLC;
				end
			end
			dsas_pkg::ST_DLC: begin
				cmd.dl_calc = 1'b1;
				state_d     = dsas_pkg::ST_INS_RD;
			end
			dsas_pkg::ST_INS_RD: begin
				cmd.rd_sel = dsas_pkg::RD_POS;
				state_d    = stat.pos_lt_cnt ? dsas_pkg::ST_INS_CMP : dsas_pkg::ST_INS_PUT;
			end
			dsas_pkg::ST_INS_CMP: begin
				cmd.ins_step = 1'b1;
				state_d      = stat.ins_adv ? dsas_pkg::ST_INS_RD : dsas_pkg::ST_INS_PUT;
			end
			dsas_pkg::ST_INS_PUT: begin
				cmd.ins_put = 1'b1;
				state_d     = dsas_pkg::ST_FRD;
			end
			dsas_pkg::ST_QRD: begin
				cmd.rd_sel = dsas_pkg::RD_TGT;
				state_d    = dsas_pkg::ST_QCMP;
			end
			dsas_pkg::ST_QCMP: begin
				cmd.q_calc = 1'b1;
				state_d    = dsas_pkg::ST_FRD;
			end
			dsas_pkg::ST_FRD: begin
				state_d = dsas_pkg::ST_FIN;
			end
			dsas_pkg::ST_FIN: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = dsas_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dsas_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/deadline_sorted_alarm_scheduler.sv
// A set and a firing periodic dispatch walk the deadline-ordered list; a firing periodic
// dispatch with a nonzero period first passes through the iterative modulo unit.
// One event at a time: the next is taken in the cycle after its result is loaded, even while
// that result waits. Reset is asynchronous and clears all alarms; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Deadline-sorted alarm scheduler
// Top level: configuration register port, controller and datapath.
// ----------------------------------------------------------------------------
module deadline_sorted_alarm_scheduler #(
	parameter int unsigned ALARM_SLOTS = 16,
	parameter int unsigned TIME_WIDTH  = 48
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dsas_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  mode,
	input  logic [3:0]                  alarm_id,
	input  logic [47:0]                 alarm_interval,
	input  logic                        periodic,
	input  logic [47:0]                 now_ms,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        fired,
	output logic [3:0]                  fired_id,
	output logic [47:0]                 time_left,
	output logic                        is_pending,
	output logic                        has_front,
	output logic [47:0]                 front_deadline_ms,
	output logic                        short_wait
);

	logic [dsas_pkg::THRESH_W-1:0] thresh_q;
	logic                          reg_sel;
	dsas_pkg::cmd_t                cmd;
	dsas_pkg::stat_t               stat;

	assign reg_sel = (paddr[dsas_pkg::APB_AW-1:2] == dsas_pkg::REG_THRESH);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? 32'(thresh_q) : '0;

	// Threshold register write on the access phase of a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= dsas_pkg::THRESH_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			thresh_q <= pwdata[dsas_pkg::THRESH_W-1:0];
		end
	end

	dsas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dsas_datapath #(
		.ALARM_SLOTS (ALARM_SLOTS),
		.TIME_WIDTH  (TIME_WIDTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.thresh            (thresh_q),
		.mode              (mode),
		.alarm_id          (alarm_id),
		.alarm_interval    (alarm_interval),
		.periodic          (periodic),
		.now_ms            (now_ms),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.fired             (fired),
		.fired_id          (fired_id),
		.time_left         (time_left),
		.is_pending        (is_pending),
		.has_front         (has_front),
		.front_deadline_ms (front_deadline_ms),
		.short_wait        (short_wait)
	);

endmodule

// File: rtl/dsas_checker.sv
// ----------------------------------------------------------------------------
// Alarm scheduler port checker
// Checks result consistency and handshake behavior seen at the top level.
// ----------------------------------------------------------------------------
module dsas_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [dsas_pkg::APB_AW-1:0] paddr,
	input logic [31:0]                 pwdata,
	input logic [31:0]                 prdata,
	input logic                        pready,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic [1:0]                  mode,
	input logic [3:0]                  alarm_id,
	input logic [47:0]                 alarm_interval,
	input logic                        periodic,
	input logic [47:0]                 now_ms,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        fired,
	input logic [3:0]                  fired_id,
	input logic [47:0]                 time_left,
	input logic                        is_pending,
	input logic                        has_front,
	input logic [47:0]                 front_deadline_ms,
	input logic                        short_wait
);

	// A waiting result holds until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(fired_id) && $stable(front_deadline_ms))
		else $error("result changed while stalled");

	// The unit works on one event at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("event taken while busy");

	// A slot number is only reported for a fired alarm.
	a_fired_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !fired |-> fired_id == 4'd0)
		else $error("fired_id set without fire");

	// With nothing pending there is no front and no short wait.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_front |-> front_deadline_ms == 48'd0 && !short_wait && !is_pending)
		else $error("empty queue reports a front");

	// Only a query reports remaining time, and a query never fires.
	a_query: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && time_left != 48'd0 |-> !fired && is_pending)
		else $error("remaining time with fire or without alarm");

endmodule

bind deadline_sorted_alarm_scheduler dsas_checker u_dsas_checker (.*);
